// ===== rtl/qtt_pkg.sv =====
package qtt_pkg;

  localparam int POS_BITS_DEF    = 16;
  localparam int KW_MAX_LEN_DEF  = 6;
  localparam int KW_COUNT        = 8;
  localparam int LINE_BITS       = 16;

  // request codes
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // result item kinds
  localparam logic ITEM_TOKEN  = 1'b0;
  localparam logic ITEM_STATUS = 1'b1;

  // status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_UNENDED  = 2'd2;
  localparam logic [1:0] ST_BAD_CHAR = 2'd3;

  // token kinds
  localparam logic [4:0] TK_IDENT   = 5'd0;
  localparam logic [4:0] TK_NUMBER  = 5'd1;
  localparam logic [4:0] TK_STRING  = 5'd2;
  localparam logic [4:0] TK_KW_BASE = 5'd3;
  localparam logic [4:0] TK_LPAREN  = 5'd11;
  localparam logic [4:0] TK_RPAREN  = 5'd12;
  localparam logic [4:0] TK_PLUS    = 5'd13;
  localparam logic [4:0] TK_MINUS   = 5'd14;
  localparam logic [4:0] TK_STAR    = 5'd15;
  localparam logic [4:0] TK_SLASH   = 5'd16;
  localparam logic [4:0] TK_COMMA   = 5'd17;
  localparam logic [4:0] TK_SEMI    = 5'd18;
  localparam logic [4:0] TK_EQUAL   = 5'd19;
  localparam logic [4:0] TK_GREATER = 5'd20;
  localparam logic [4:0] TK_LESS    = 5'd21;
  localparam logic [4:0] TK_GE      = 5'd22;
  localparam logic [4:0] TK_LE      = 5'd23;

  // characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  // keywords, first character in the low byte: and or not select from where ya na
  localparam logic [63:0] KW_WORD [KW_COUNT] = '{
    64'h0000_0000_0064_6E61,
    64'h0000_0000_0000_726F,
    64'h0000_0000_0074_6F6E,
    64'h0000_7463_656C_6573,
    64'h0000_0000_6D6F_7266,
    64'h0000_0065_7265_6877,
    64'h0000_0000_0000_6179,
    64'h0000_0000_0000_616E
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd2, 4'd3, 4'd6, 4'd4, 4'd5, 4'd2, 4'd2
  };

  typedef struct packed {
    logic       req_type;
    logic [7:0] text_byte;
  } qtt_in_t;

  typedef struct packed {
    logic        item_kind;
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [1:0]  status_code;
    logic        last_of_run;
  } qtt_out_t;

endpackage

// ===== rtl/query_text_tokenizer_top.sv =====
// Byte-serial lexer for a small query language. Send one text byte per
// word (req_type 0) and close each text with an end word (req_type 1).
// Every finished token comes out as a token word with its kind, start
// offset, length and line; the end word gives one status word (done,
// unended statement or unexpected character) and returns the lexer to its
// reset state for the next text. A bad character halts the lexer: later
// text bytes give nothing until the end word. One input word is taken per
// cycle while in_stall is low: it lands in an input register, the lexer
// step is combinational between that register and a four-deep result
// queue, and the step advances whenever the queue has room for two
// results. A byte that closes one token and then completes a one-character
// token or raises an error yields two results, and the single result port
// then drains them at one per cycle while out_stall is low. A word passes
// through the input register and then the result queue on its way out.
module query_text_tokenizer_top
  import qtt_pkg::*;
#(
  parameter int POS_BITS        = POS_BITS_DEF,
  parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qtt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output qtt_out_t out_data
);

  localparam int WIN_BITS = 8 * KEYWORD_MAX_LEN;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  typedef enum logic [2:0] {
    M_INIT   = 3'd0,
    M_IDENT  = 3'd1,
    M_NUMBER = 3'd2,
    M_STRING = 3'd3,
    M_LT     = 3'd4,
    M_GT     = 3'd5,
    M_HALT   = 3'd6
  } mode_t;

  // input register
  logic    in_valid_r;
  qtt_in_t in_data_r;

  // lexer state
  mode_t                mode_r,      mode_nxt;
  logic [POS_BITS-1:0]  pstart_r,    pstart_nxt;
  logic [POS_BITS-1:0]  plen_r,      plen_nxt;
  logic [WIN_BITS-1:0]  win_r,       win_nxt;
  logic                 dot_r,       dot_nxt;
  logic [LINE_BITS-1:0] line_r,      line_nxt;
  logic [POS_BITS-1:0]  offset_r,    offset_nxt;
  logic                 semi_r,      semi_nxt;

  // result queue
  qtt_out_t   q_mem_r [4];
  logic [1:0] q_wr_r, q_rd_r;
  logic [2:0] q_cnt_r, q_cnt_nxt;

  logic       advance;
  logic       pop;
  logic [7:0] b;
  logic       is_alpha, is_digit;
  logic [POS_BITS-1:0] pos_inc, plen_inc;

  // fresh-token action of a byte, as lexed from the initial mode
  logic                ia_tok, ia_err, ia_begin;
  logic [4:0]          ia_kind;
  mode_t               ia_mode;
  logic [POS_BITS-1:0] ia_pstart, ia_plen;
  logic [WIN_BITS-1:0] ia_win;
  qtt_out_t            ia_res;

  logic [4:0] ident_kind;

  // step results
  logic     pre_v, pre_tok, use_ia;
  qtt_out_t pre_res;
  logic     v0, v1;
  qtt_out_t r0, r1;
  logic     ia_semi;

  function automatic qtt_out_t make_tok(logic [4:0] kind, logic [POS_BITS-1:0] start,
                                        logic [POS_BITS-1:0] len,
                                        logic [LINE_BITS-1:0] line);
    qtt_out_t r;
    r.item_kind    = ITEM_TOKEN;
    r.token_kind   = kind;
    r.token_start  = 16'(start);
    r.token_length = 16'(len);
    r.line_number  = line;
    r.status_code  = ST_NONE;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  function automatic qtt_out_t make_stat(logic [1:0] code, logic [LINE_BITS-1:0] line);
    qtt_out_t r;
    r.item_kind    = ITEM_STATUS;
    r.token_kind   = TK_IDENT;
    r.token_start  = '0;
    r.token_length = '0;
    r.line_number  = line;
    r.status_code  = code;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // advance the step only when the queue can take two results
  assign advance  = in_valid_r && (q_cnt_r <= 3'd2);
  assign in_stall = in_valid_r && !advance;
  assign pop      = out_valid && !out_stall;
  assign out_valid = (q_cnt_r != 3'd0);
  assign out_data  = q_mem_r[q_rd_r];

  assign b        = in_data_r.text_byte;
  assign is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign pos_inc  = (offset_r == POS_MAX) ? offset_r : offset_r + 1'b1;
  assign plen_inc = (plen_r == POS_MAX) ? plen_r : plen_r + 1'b1;

  // initial-mode decode of the byte at the current offset
  always_comb begin
    ia_tok    = 1'b0;
    ia_err    = 1'b0;
    ia_begin  = 1'b0;
    ia_kind   = TK_IDENT;
    ia_mode   = M_INIT;
    ia_pstart = offset_r;
    ia_plen   = '0;
    ia_win    = '0;
    if (b == CH_SPACE) begin
      ia_mode = M_INIT;
    end else if (is_alpha) begin
      ia_mode  = M_IDENT;
      ia_begin = 1'b1;
      ia_plen  = POS_BITS'(1);
      ia_win   = WIN_BITS'(b);
    end else if (is_digit) begin
      ia_mode  = M_NUMBER;
      ia_begin = 1'b1;
      ia_plen  = POS_BITS'(1);
    end else begin
      unique case (b)
        CH_QUOTE: begin
          ia_mode   = M_STRING;
          ia_begin  = 1'b1;
          ia_pstart = pos_inc;
        end
        CH_LT: begin
          ia_mode  = M_LT;
          ia_begin = 1'b1;
          ia_plen  = POS_BITS'(1);
        end
        CH_GT: begin
          ia_mode  = M_GT;
          ia_begin = 1'b1;
          ia_plen  = POS_BITS'(1);
        end
        CH_LPAREN: begin ia_tok = 1'b1; ia_kind = TK_LPAREN; end
        CH_RPAREN: begin ia_tok = 1'b1; ia_kind = TK_RPAREN; end
        CH_PLUS:   begin ia_tok = 1'b1; ia_kind = TK_PLUS;   end
        CH_MINUS:  begin ia_tok = 1'b1; ia_kind = TK_MINUS;  end
        CH_STAR:   begin ia_tok = 1'b1; ia_kind = TK_STAR;   end
        CH_SLASH:  begin ia_tok = 1'b1; ia_kind = TK_SLASH;  end
        CH_COMMA:  begin ia_tok = 1'b1; ia_kind = TK_COMMA;  end
        CH_SEMI:   begin ia_tok = 1'b1; ia_kind = TK_SEMI;   end
        CH_EQUAL:  begin ia_tok = 1'b1; ia_kind = TK_EQUAL;  end
        default: begin
          ia_err  = 1'b1;
          ia_mode = M_HALT;
        end
      endcase
    end
    ia_res = ia_err ? make_stat(ST_BAD_CHAR, line_r)
                    : make_tok(ia_kind, offset_r, POS_BITS'(1), line_r);
  end

  // keyword match on the collected window: one compare per keyword
  always_comb begin
    ident_kind = TK_IDENT;
    if (plen_r <= POS_BITS'(KEYWORD_MAX_LEN)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if ((plen_r == POS_BITS'(KW_LEN[i])) && (win_r == WIN_BITS'(KW_WORD[i]))) begin
          ident_kind = TK_KW_BASE + 5'(i);
        end
      end
    end
  end

  // one lexer step
  always_comb begin
    mode_nxt   = mode_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    win_nxt    = win_r;
    dot_nxt    = dot_r;
    line_nxt   = line_r;
    offset_nxt = offset_r;
    semi_nxt   = semi_r;
    pre_v      = 1'b0;
    pre_tok    = 1'b0;
    pre_res    = make_tok(TK_IDENT, pstart_r, plen_r, line_r);
    use_ia     = 1'b0;
    v0         = 1'b0;
    v1         = 1'b0;
    r0         = pre_res;
    r1         = ia_res;
    ia_semi    = 1'b0;

    if (in_data_r.req_type == REQ_END) begin
      unique case (mode_r)
        M_INIT:                                  r0 = make_stat(semi_r ? ST_DONE : ST_UNENDED,
                                                                line_r);
        M_IDENT, M_NUMBER, M_STRING, M_LT, M_GT: r0 = make_stat(ST_UNENDED, line_r);
        default:                                 r0 = make_stat(ST_BAD_CHAR, line_r);
      endcase
      v0         = 1'b1;
      mode_nxt   = M_INIT;
      pstart_nxt = '0;
      plen_nxt   = '0;
      win_nxt    = '0;
      dot_nxt    = 1'b0;
      line_nxt   = LINE_BITS'(1);
      offset_nxt = '0;
      semi_nxt   = 1'b0;
    end else begin
      offset_nxt = pos_inc;
      unique case (mode_r)
        M_INIT: use_ia = 1'b1;
        M_IDENT: begin
          if (is_alpha || is_digit || (b == CH_USCORE)) begin
            for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
              if (plen_r == POS_BITS'(j)) win_nxt[8*j +: 8] = b;
            end
            plen_nxt = plen_inc;
          end else begin
            pre_v   = 1'b1;
            pre_tok = 1'b1;
            pre_res = make_tok(ident_kind, pstart_r, plen_r, line_r);
            use_ia  = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit) begin
            plen_nxt = plen_inc;
          end else if (b == CH_DOT) begin
            if (dot_r) begin
              pre_v    = 1'b1;
              pre_res  = make_stat(ST_BAD_CHAR, line_r);
              mode_nxt = M_HALT;
            end else begin
              dot_nxt  = 1'b1;
              plen_nxt = plen_inc;
            end
          end else if (is_alpha) begin
            pre_v    = 1'b1;
            pre_res  = make_stat(ST_BAD_CHAR, line_r);
            mode_nxt = M_HALT;
          end else begin
            pre_v   = 1'b1;
            pre_tok = 1'b1;
            pre_res = make_tok(TK_NUMBER, pstart_r, plen_r, line_r);
            use_ia  = 1'b1;
          end
        end
        M_STRING: begin
          if (b == CH_QUOTE) begin
            pre_v    = 1'b1;
            pre_tok  = 1'b1;
            pre_res  = make_tok(TK_STRING, pstart_r, plen_r, line_r);
            mode_nxt = M_INIT;
          end else begin
            plen_nxt = plen_inc;
          end
        end
        M_LT, M_GT: begin
          pre_v   = 1'b1;
          pre_tok = 1'b1;
          if (b == CH_EQUAL) begin
            pre_res  = make_tok((mode_r == M_LT) ? TK_LE : TK_GE, pstart_r,
                                POS_BITS'(2), line_r);
            mode_nxt = M_INIT;
          end else begin
            // close the single-character compare, then lex the byte afresh
            pre_res = make_tok((mode_r == M_LT) ? TK_LESS : TK_GREATER, pstart_r,
                               plen_r, line_r);
            use_ia  = 1'b1;
          end
        end
        default: ;
      endcase

      if (use_ia) begin
        mode_nxt = ia_mode;
        if (ia_begin) begin
          pstart_nxt = ia_pstart;
          plen_nxt   = ia_plen;
          win_nxt    = ia_win;
          dot_nxt    = 1'b0;
        end
      end
      ia_semi = use_ia && ia_tok && (ia_kind == TK_SEMI);
      if (pre_tok || (use_ia && ia_tok)) semi_nxt = ia_semi;
      if (ia_semi && (line_r != LINE_MAX)) line_nxt = line_r + 1'b1;

      // pack results: the mode's own result first, then the fresh one
      if (pre_v) begin
        v0 = 1'b1;
        r0 = pre_res;
        v1 = use_ia && (ia_tok || ia_err);
        r1 = ia_res;
      end else if (use_ia && (ia_tok || ia_err)) begin
        v0 = 1'b1;
        r0 = ia_res;
      end
    end
    r0.last_of_run = !v1;
    r1.last_of_run = 1'b1;
  end

  always_comb begin
    q_cnt_nxt = q_cnt_r - {2'b00, pop};
    if (advance) q_cnt_nxt = q_cnt_nxt + {2'b00, v0} + {2'b00, v1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      mode_r     <= M_INIT;
      pstart_r   <= '0;
      plen_r     <= '0;
      win_r      <= '0;
      dot_r      <= 1'b0;
      line_r     <= LINE_BITS'(1);
      offset_r   <= '0;
      semi_r     <= 1'b0;
      q_wr_r     <= '0;
      q_rd_r     <= '0;
      q_cnt_r    <= '0;
    end else begin
      // take a new word whenever the input register is empty or moving on
      if (!in_valid_r || advance) begin
        in_valid_r <= in_valid;
        if (in_valid) in_data_r <= in_data;
      end
      if (advance) begin
        mode_r   <= mode_nxt;
        pstart_r <= pstart_nxt;
        plen_r   <= plen_nxt;
        win_r    <= win_nxt;
        dot_r    <= dot_nxt;
        line_r   <= line_nxt;
        offset_r <= offset_nxt;
        semi_r   <= semi_nxt;
        if (v0) q_mem_r[q_wr_r] <= r0;
        if (v1) q_mem_r[q_wr_r + 2'd1] <= r1;
        q_wr_r <= q_wr_r + {1'b0, v0} + {1'b0, v1};
      end
      if (pop) q_rd_r <= q_rd_r + 2'd1;
      q_cnt_r <= q_cnt_nxt;
    end
  end

endmodule

// ===== sim/qtt_checker.sv =====
`timescale 1ns / 100ps

module qtt_checker
  import qtt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  qtt_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  qtt_out_t out_data,
  output int       fail_count,
  output int       pending_words,
  output int       token_words,
  output int       status_words
);

  localparam int unsigned POS_LIMIT  = (32'd1 << POS_BITS_DEF) - 1;
  localparam int unsigned LINE_LIMIT = (32'd1 << LINE_BITS) - 1;
  localparam int          TEXT_BITS  = 8 * KW_MAX_LEN_DEF;

  localparam logic [4:0] TK_AND    = TK_KW_BASE;
  localparam logic [4:0] TK_OR     = TK_KW_BASE + 5'd1;
  localparam logic [4:0] TK_NOT    = TK_KW_BASE + 5'd2;
  localparam logic [4:0] TK_SELECT = TK_KW_BASE + 5'd3;
  localparam logic [4:0] TK_FROM   = TK_KW_BASE + 5'd4;
  localparam logic [4:0] TK_WHERE  = TK_KW_BASE + 5'd5;
  localparam logic [4:0] TK_YA     = TK_KW_BASE + 5'd6;
  localparam logic [4:0] TK_NA     = TK_KW_BASE + 5'd7;
  // status words carry a zero kind
  localparam logic [4:0] NO_KIND   = TK_IDENT;

  typedef enum logic [2:0] {
    LX_IDLE, LX_IDENT, LX_NUMBER, LX_STRING, LX_LESS, LX_GREATER, LX_HALTED
  } lex_state_t;

  lex_state_t           lex_state;
  logic [4:0]           held_kind;
  int unsigned          held_start;
  int unsigned          held_length;
  logic [TEXT_BITS-1:0] held_text;   // first character in the high byte
  logic                 seen_dot;
  int unsigned          line_no;
  int unsigned          text_pos;
  logic                 ended_on_semi;
  qtt_out_t             expected_words[$];

  function automatic int unsigned bump(int unsigned v);
    return (v < POS_LIMIT) ? v + 1 : POS_LIMIT;
  endfunction

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic clear_lexer();
    lex_state     = LX_IDLE;
    held_kind     = TK_IDENT;
    held_start    = 0;
    held_length   = 0;
    held_text     = '0;
    seen_dot      = 1'b0;
    line_no       = 1;
    text_pos      = 0;
    ended_on_semi = 1'b0;
  endtask

  task automatic push_word(logic item, logic [4:0] kind, int unsigned start,
                           int unsigned length, logic [1:0] status);
    qtt_out_t w;
    w.item_kind    = item;
    w.token_kind   = kind;
    w.token_start  = 16'(start);
    w.token_length = 16'(length);
    w.line_number  = 16'(line_no);
    w.status_code  = status;
    w.last_of_run  = 1'b0;
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic emit_token(logic [4:0] kind, int unsigned start, int unsigned length);
    push_word(ITEM_TOKEN, kind, start, length, ST_NONE);
    ended_on_semi = (kind == TK_SEMI);
    if (kind == TK_SEMI && line_no < LINE_LIMIT) line_no++;
  endtask

  task automatic flag_bad_char();
    push_word(ITEM_STATUS, NO_KIND, 0, 0, ST_BAD_CHAR);
    lex_state = LX_HALTED;
  endtask

  task automatic open_token(lex_state_t st, logic [4:0] kind, int unsigned start,
                            int unsigned length);
    lex_state   = st;
    held_kind   = kind;
    held_start  = start;
    held_length = length;
    held_text   = '0;
    seen_dot    = 1'b0;
  endtask

  task automatic ident_take(logic [7:0] b);
    if (held_length < KW_MAX_LEN_DEF) held_text = {held_text[TEXT_BITS-9:0], b};
    held_length = bump(held_length);
  endtask

  // exact lowercase match; the window holds the whole name when it is short enough
  function automatic logic [4:0] ident_kind();
    if (held_length > KW_MAX_LEN_DEF) return TK_IDENT;
    case (held_text)
      "and":    return TK_AND;
      "or":     return TK_OR;
      "not":    return TK_NOT;
      "select": return TK_SELECT;
      "from":   return TK_FROM;
      "where":  return TK_WHERE;
      "ya":     return TK_YA;
      "na":     return TK_NA;
      default:  return TK_IDENT;
    endcase
  endfunction

  task automatic lex_symbol(logic [7:0] b, int unsigned pos);
    lex_state = LX_IDLE;
    case (b)
      CH_SPACE:  ;
      CH_QUOTE:  open_token(LX_STRING, TK_STRING, bump(pos), 0);
      CH_LT:     open_token(LX_LESS, TK_LESS, pos, 1);
      CH_GT:     open_token(LX_GREATER, TK_GREATER, pos, 1);
      CH_LPAREN: emit_token(TK_LPAREN, pos, 1);
      CH_RPAREN: emit_token(TK_RPAREN, pos, 1);
      CH_PLUS:   emit_token(TK_PLUS, pos, 1);
      CH_MINUS:  emit_token(TK_MINUS, pos, 1);
      CH_STAR:   emit_token(TK_STAR, pos, 1);
      CH_SLASH:  emit_token(TK_SLASH, pos, 1);
      CH_COMMA:  emit_token(TK_COMMA, pos, 1);
      CH_SEMI:   emit_token(TK_SEMI, pos, 1);
      CH_EQUAL:  emit_token(TK_EQUAL, pos, 1);
      default:   flag_bad_char();
    endcase
  endtask

  task automatic lex_text(logic [7:0] b, int unsigned pos);
    // a byte other than '=' closes < or > and is then lexed from idle
    if (lex_state inside {LX_LESS, LX_GREATER}) begin
      if (b == CH_EQUAL) begin
        emit_token((lex_state == LX_LESS) ? TK_LE : TK_GE, held_start, 2);
        lex_state = LX_IDLE;
        return;
      end
      emit_token(held_kind, held_start, held_length);
      lex_state = LX_IDLE;
    end
    case (lex_state)
      LX_IDLE: begin
        if (b == CH_SPACE) ;
        else if (is_letter(b)) begin
          open_token(LX_IDENT, TK_IDENT, pos, 0);
          ident_take(b);
        end else if (is_digit(b)) open_token(LX_NUMBER, TK_NUMBER, pos, 1);
        else lex_symbol(b, pos);
      end
      LX_IDENT: begin
        if (is_letter(b) || is_digit(b) || b == CH_USCORE) ident_take(b);
        else begin
          emit_token(ident_kind(), held_start, held_length);
          lex_symbol(b, pos);
        end
      end
      LX_NUMBER: begin
        if (is_digit(b)) held_length = bump(held_length);
        else if (b == CH_DOT) begin
          if (seen_dot) flag_bad_char();
          else begin
            seen_dot    = 1'b1;
            held_length = bump(held_length);
          end
        end else if (is_letter(b)) flag_bad_char();
        else begin
          emit_token(TK_NUMBER, held_start, held_length);
          lex_symbol(b, pos);
        end
      end
      LX_STRING: begin
        if (b == CH_QUOTE) begin
          emit_token(TK_STRING, held_start, held_length);
          lex_state = LX_IDLE;
        end else held_length = bump(held_length);
      end
      default: ;
    endcase
  endtask

  task automatic predict_word(qtt_in_t w);
    int         queued;
    logic [1:0] code;
    queued = expected_words.size();
    if (w.req_type == REQ_END) begin
      if (lex_state == LX_IDLE) code = ended_on_semi ? ST_DONE : ST_UNENDED;
      else if (lex_state == LX_HALTED) code = ST_BAD_CHAR;
      else code = ST_UNENDED;
      push_word(ITEM_STATUS, NO_KIND, 0, 0, code);
      clear_lexer();
    end else begin
      lex_text(w.text_byte, text_pos);
      text_pos = bump(text_pos);
    end
    if (expected_words.size() > queued)
      expected_words[expected_words.size() - 1].last_of_run = 1'b1;
  endtask

  function automatic bit field_differs(string name, int unsigned want, int unsigned got);
    if (want == got) return 1'b0;
    $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
    return 1'b1;
  endfunction

  task automatic check_word(qtt_out_t got);
    qtt_out_t want;
    bit       bad;
    if (got.item_kind == ITEM_STATUS) status_words++;
    else token_words++;
    if (expected_words.size() == 0) begin
      $display("%0t ns: result word expected none, actual %h", $time, got);
      fail_count++;
      return;
    end
    want = expected_words.pop_front();
    bad  = 1'b0;
    bad |= field_differs("item_kind", want.item_kind, got.item_kind);
    bad |= field_differs("token_kind", want.token_kind, got.token_kind);
    bad |= field_differs("token_start", want.token_start, got.token_start);
    bad |= field_differs("token_length", want.token_length, got.token_length);
    bad |= field_differs("line_number", want.line_number, got.line_number);
    bad |= field_differs("status_code", want.status_code, got.status_code);
    bad |= field_differs("last_of_run", want.last_of_run, got.last_of_run);
    if (bad) fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_lexer();
      expected_words.delete();
      fail_count   = 0;
      token_words  = 0;
      status_words = 0;
    end else begin
      if (in_valid && !in_stall) predict_word(in_data);
      if (out_valid && !out_stall) check_word(out_data);
    end
    pending_words = expected_words.size();
  end

endmodule

// ===== sim/query_text_tokenizer_top_tb.sv =====
`timescale 1ns / 100ps

module query_text_tokenizer_top_tb;
  import qtt_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  localparam int HOLD_CYCLES  = 300;       // long output hold to back the lexer up
  localparam int RANDOM_WORDS = 1600;
  localparam int SETTLE       = 8;         // margin over the input-to-result latency
  localparam int LIMIT_CYCLES = 2_000_000;

  typedef enum int {STALL_NONE, STALL_SOME, STALL_EVERY_FOURTH, STALL_HALF} stall_style_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  qtt_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  qtt_out_t out_data;

  int fail_count;
  int pending_words;
  int token_words;
  int status_words;

  int words_sent  = 0;
  int texts_sent  = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  bit hold_req    = 1'b0;   // raised by the stimulus, serviced by the receiver
  bit hold_done;

  query_text_tokenizer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The checker sits beside the lexer, predicts every result word and
  // compares; this module only makes stimulus and gives the verdict.
  qtt_checker lex_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .token_words   (token_words),
    .status_words  (status_words)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Offer one word and hold it until it is taken. Inputs move on the falling
  // edge; acceptance is judged at the rising edge. Valid only drops for a
  // gap between bursts, never between two back-to-back words.
  task automatic send_word(logic req, logic [7:0] b);
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
      // mostly short bursts, now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 50)
                                               : $urandom_range(24, 1);
    end
    in_valid = 1'b1;
    in_data  = '{req_type: req, text_byte: b};
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    words_sent++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_word(REQ_BYTE, s[i]);
  endtask

  // the byte of an end word is ignored, so let it wander
  task automatic send_end();
    send_word(REQ_END, 8'($urandom_range(255, 0)));
    texts_sent++;
  endtask

  // Hold the sender until every predicted word has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  function automatic string keyword_text(int k);
    case (k)
      0:       return "and";
      1:       return "or";
      2:       return "not";
      3:       return "select";
      4:       return "from";
      5:       return "where";
      6:       return "ya";
      default: return "na";
    endcase
  endfunction

  // letters, digits and underscore; a leading character is a letter
  function automatic logic [7:0] name_char(bit lead);
    int k;
    k = $urandom_range(lead ? 51 : 62, 0);
    if (k < 26) return 8'("a" + k);
    if (k < 52) return 8'("A" + k - 26);
    if (k < 62) return 8'("0" + k - 52);
    return CH_USCORE;
  endfunction

  task automatic add_byte(ref logic [7:0] text[$], input logic [7:0] b);
    text.insert(text.size(), b);
  endtask

  task automatic push_string(ref logic [7:0] text[$], input string s);
    for (int i = 0; i < s.len(); i++) add_byte(text, s[i]);
  endtask

  // Append one random lexeme, mostly followed by a space. Without the space
  // neighbours fuse: a name runs into a number, a number into a letter
  // (an error), or a byte closes one token and opens the next.
  task automatic add_token(ref logic [7:0] text[$]);
    string syms;
    string kw;
    int    n;
    int    pick;
    syms = "()+-*/,=<>";
    pick = $urandom_range(11, 0);
    case (pick)
      0, 1, 2: begin
        kw = keyword_text($urandom_range(7, 0));
        case ($urandom_range(4, 0))
          0: kw = {kw, "s"};       // one byte too long to match
          1: kw = kw.toupper();    // keywords are lowercase only
          2: kw = {kw, "_x1"};     // suffix that spoils the keyword match
          default: ;
        endcase
        push_string(text, kw);
      end
      3: begin
        add_byte(text, name_char(1'b1));
        repeat ($urandom_range(8, 0)) add_byte(text, name_char(1'b0));
      end
      4, 5: begin
        repeat ($urandom_range(4, 1)) add_byte(text, 8'("0" + $urandom_range(9, 0)));
        if ($urandom_range(2, 0) == 0) begin
          add_byte(text, CH_DOT);
          repeat ($urandom_range(3, 0)) add_byte(text, 8'("0" + $urandom_range(9, 0)));
        end
      end
      6: begin
        add_byte(text, CH_QUOTE);
        repeat ($urandom_range(6, 0)) begin
          n = $urandom_range(255, 0);
          add_byte(text, (n == CH_QUOTE) ? CH_SPACE : 8'(n));
        end
        add_byte(text, CH_QUOTE);
      end
      7: push_string(text, ($urandom_range(1, 0) == 0) ? "<=" : ">=");
      default: add_byte(text, syms[$urandom_range(syms.len() - 1, 0)]);
    endcase
    if ($urandom_range(9, 0) < 6) add_byte(text, CH_SPACE);
  endtask

  // One text: mostly well-formed statements closed by ';', the rest broken
  // on purpose, then the end word.
  task automatic send_random_text();
    logic [7:0] text[$];
    int         flavour;
    int         n_stmt;
    flavour = $urandom_range(13, 0);
    n_stmt  = (flavour == 6) ? 0 : $urandom_range(3, 1);
    repeat (n_stmt) begin
      repeat ($urandom_range(7, 1)) add_token(text);
      add_byte(text, CH_SEMI);
      if ($urandom_range(1, 0) == 0) add_byte(text, CH_SPACE);
    end
    case (flavour)
      0: text.insert($urandom_range(text.size(), 0), 8'($urandom_range(255, 0)));
      1: repeat ($urandom_range(3, 1)) if (text.size() > 0) void'(text.pop_back());
      2: push_string(text, "1.2.3");
      3: push_string(text, "7k");
      4: add_byte(text, CH_LT);
      5: add_byte(text, CH_LPAREN);
      default: ;
    endcase
    foreach (text[i]) send_word(REQ_BYTE, text[i]);
    send_end();
  endtask

  // Receiver: switch between stall patterns of its own, and service one long
  // hold when asked, counting the held cycles here.
  initial begin : receiver
    stall_style_t style;
    int           span;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      span  = $urandom_range(200, 20);
      style = stall_style_t'($urandom_range(3, 0));
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        if (hold_req && !hold_done) begin
          out_stall = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end
        case (style)
          STALL_NONE:         out_stall = 1'b0;
          STALL_SOME:         out_stall = ($urandom_range(99, 0) < 30);
          STALL_EVERY_FOURTH: out_stall = (k % 4 == 3);
          default:            out_stall = ($urandom_range(1, 0) == 1);
        endcase
      end
    end
  end

  initial begin : stimulus
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed texts. Name, '<' closed by a name, '>=', a dotted number and
    // ';' ending in done. Then a string of the extreme bytes, a second dot
    // (error), a byte ignored while halted and the end repeating the error.
    // Then an end inside a name, and a letter straight after a number.
    send_string("x<y>=1.5;");
    send_end();
    send_word(REQ_BYTE, CH_QUOTE);
    send_word(REQ_BYTE, 8'hFF);
    send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, CH_QUOTE);
    send_string("1.2.a");
    send_end();
    send_string("ab");
    send_end();
    send_string("9x");
    send_end();
    wait_drained();

    // Back the lexer up: the receiver holds off for a long stretch while
    // words keep coming, each ';' after a name giving two results.
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (20) send_string("q;");
    send_end();
    gaps_on = 1'b1;
    wait_drained();

    while (words_sent < RANDOM_WORDS) send_random_text();

    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (SETTLE) @(negedge clk);

    $display("Ran %0d input words over %0d texts; checked %0d token and %0d status words.",
             words_sent, texts_sent, token_words, status_words);
    $display("Covered keywords, malformed text, halted input and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_words == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/qtt_pkg.sv
rtl/query_text_tokenizer_top.sv
sim/qtt_checker.sv
sim/query_text_tokenizer_top_tb.sv
